// File: hdl/ras_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ras_pkg
// Shared types, widths and helpers for the return address stack.
// ----------------------------------------------------------------------------
package ras_pkg;

    localparam int MAX_DEPTH = 16;
    localparam int ADDR_W    = 64;
    localparam int CNT_W     = 32;
    localparam int OCC_W     = 5;
    localparam int CFG_W     = 5;
    localparam int KIND_W    = 2;
    localparam int TOP_W     = $clog2(MAX_DEPTH + 1);
    localparam int ENT_W     = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
    localparam int DEPTH_RESET = (16 > MAX_DEPTH) ? MAX_DEPTH : 16;

    typedef enum logic [KIND_W-1:0] {
        KIND_PUSH  = 2'd0,
        KIND_POP   = 2'd1,
        KIND_PEEK  = 2'd2,
        KIND_CLEAR = 2'd3
    } kind_t;

    typedef enum logic {
        ST_EMPTY,
        ST_HOLD
    } state_t;

    typedef struct packed {
        logic take;
        logic push;
        logic push_shift;
        logic pop;
        logic underflow;
        logic peek;
        logic clear;
    } cmd_t;

    typedef struct packed {
        logic empty;
        logic full;
    } status_t;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
        return (&c) ? c : c + CNT_W'(1);
    endfunction

    function automatic logic [TOP_W-1:0] limit_depth(input logic [CFG_W-1:0] v);
        logic [TOP_W-1:0] res;
        if (v == '0)
        begin
            res = TOP_W'(1);
        end
        else if (int'(v) > MAX_DEPTH)
        begin
            res = TOP_W'(MAX_DEPTH);
        end
        else
        begin
            res = TOP_W'(v);
        end
        return res;
    endfunction

endpackage

// File: hdl/ras_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ras_ctrl
// Handshake controller: owns the output holding state and decodes each
// accepted item into datapath commands.
// ----------------------------------------------------------------------------
module ras_ctrl
    import ras_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [KIND_W-1:0]  kind,
    output logic               out_valid,
    input  logic               out_ready,
    input  status_t            status,
    output cmd_t               cmd
);

    state_t state_reg;
    state_t state_next;
    logic   accept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_EMPTY;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_EMPTY:
            begin
                if (in_valid)
                begin
                    state_next = ST_HOLD;
                end
            end
            ST_HOLD:
            begin
                if (out_ready && !in_valid)
                begin
                    state_next = ST_EMPTY;
                end
            end
            default:
            begin
                state_next = ST_EMPTY;
            end
        endcase
    end

    always_comb
    begin
        in_ready  = 1'b0;
        out_valid = 1'b0;
        unique case (state_reg)
            ST_EMPTY:
            begin
                in_ready = 1'b1;
            end
            ST_HOLD:
            begin
                in_ready  = out_ready;
                out_valid = 1'b1;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    assign accept = in_valid && in_ready;

    always_comb
    begin
        cmd = '0;
        if (accept)
        begin
            cmd.take = 1'b1;
            unique case (kind_t'(kind))
                KIND_PUSH:
                begin
                    cmd.push       = 1'b1;
                    cmd.push_shift = status.full;
                end
                KIND_POP:
                begin
                    cmd.pop       = !status.empty;
                    cmd.underflow = status.empty;
                end
                KIND_PEEK:
                begin
                    cmd.peek = !status.empty;
                end
                KIND_CLEAR:
                begin
                    cmd.clear = 1'b1;
                end
                default:
                begin
                    cmd.clear = 1'b0;
                end
            endcase
        end
    end

endmodule

// File: hdl/ras_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ras_dp
// Datapath: entry registers with parallel shift, top pointer, depth
// register, saturating counters and the result registers.
// ----------------------------------------------------------------------------
module ras_dp
    import ras_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  cmd_t               cmd,
    output status_t            status,
    input  logic [ADDR_W-1:0]  push_addr,
    input  logic               cfg_wr_en,
    input  logic [CFG_W-1:0]   cfg_wr_data,
    output logic               addr_valid,
    output logic [ADDR_W-1:0]  top_addr,
    output logic [OCC_W-1:0]   occupancy,
    output logic [CNT_W-1:0]   push_count,
    output logic [CNT_W-1:0]   pop_count,
    output logic [CNT_W-1:0]   overflow_count,
    output logic [CNT_W-1:0]   underflow_count
);

    logic [ADDR_W-1:0] entries_reg [MAX_DEPTH];
    logic [TOP_W-1:0]  top_reg;
    logic [TOP_W-1:0]  top_next;
    logic [TOP_W-1:0]  depth_reg;
    logic [CNT_W-1:0]  push_cnt_reg;
    logic [CNT_W-1:0]  pop_cnt_reg;
    logic [CNT_W-1:0]  ovf_cnt_reg;
    logic [CNT_W-1:0]  unf_cnt_reg;
    logic              addr_valid_reg;
    logic [ADDR_W-1:0] top_addr_reg;
    logic [ENT_W-1:0]  rd_idx;
    logic [ENT_W-1:0]  wr_idx;
    logic              clear_all;

    assign status.empty = (top_reg == '0);
    assign status.full  = (top_reg == depth_reg);
    assign rd_idx       = ENT_W'(top_reg - TOP_W'(1));
    assign wr_idx       = ENT_W'(top_reg);
    assign clear_all    = cmd.clear || cfg_wr_en;

    always_comb
    begin
        top_next = top_reg;
        if (clear_all)
        begin
            top_next = '0;
        end
        else if (cmd.push && !cmd.push_shift)
        begin
            top_next = top_reg + TOP_W'(1);
        end
        else if (cmd.pop)
        begin
            top_next = top_reg - TOP_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            top_reg      <= '0;
            depth_reg    <= TOP_W'(DEPTH_RESET);
            push_cnt_reg <= '0;
            pop_cnt_reg  <= '0;
            ovf_cnt_reg  <= '0;
            unf_cnt_reg  <= '0;
        end
        else
        begin
            top_reg <= top_next;
            if (cfg_wr_en)
            begin
                depth_reg <= limit_depth(cfg_wr_data);
            end
            if (clear_all)
            begin
                push_cnt_reg <= '0;
                pop_cnt_reg  <= '0;
                ovf_cnt_reg  <= '0;
                unf_cnt_reg  <= '0;
            end
            else
            begin
                if (cmd.push)
                begin
                    push_cnt_reg <= sat_inc(push_cnt_reg);
                end
                if (cmd.push_shift)
                begin
                    ovf_cnt_reg <= sat_inc(ovf_cnt_reg);
                end
                if (cmd.pop)
                begin
                    pop_cnt_reg <= sat_inc(pop_cnt_reg);
                end
                if (cmd.underflow)
                begin
                    unf_cnt_reg <= sat_inc(unf_cnt_reg);
                end
            end
        end
    end

    // entries above the top are never read, so no reset or clear is needed
    always_ff @(posedge clk)
    begin
        if (cmd.push && cmd.push_shift)
        begin
            for (int i = 0; i < MAX_DEPTH; i++)
            begin
                if (i + 1 < int'(depth_reg))
                begin
                    entries_reg[i] <= entries_reg[(i + 1) % MAX_DEPTH];
                end
                else if (i + 1 == int'(depth_reg))
                begin
                    entries_reg[i] <= push_addr;
                end
            end
        end
        else if (cmd.push)
        begin
            entries_reg[wr_idx] <= push_addr;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_valid_reg <= 1'b0;
        end
        else if (cmd.take)
        begin
            addr_valid_reg <= cmd.pop || cmd.peek;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.pop || cmd.peek)
        begin
            top_addr_reg <= entries_reg[rd_idx];
        end
        else if (cmd.take)
        begin
            top_addr_reg <= '0;
        end
    end

    assign addr_valid      = addr_valid_reg;
    assign top_addr        = top_addr_reg;
    assign occupancy       = OCC_W'(top_reg);
    assign push_count      = push_cnt_reg;
    assign pop_count       = pop_cnt_reg;
    assign overflow_count  = ovf_cnt_reg;
    assign underflow_count = unf_cnt_reg;

endmodule

// File: hdl/return_address_stack.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// return_address_stack
// Branch predictor return address stack with push, pop, peek and clear,
// oldest-entry drop on overflow and saturating event counters.
//
//   channel  | handshake              | payload
//   ---------+------------------------+------------------------------------
//   in       | in_valid / in_ready    | kind, push_addr
//   out      | out_valid / out_ready  | addr_valid, top_addr, occupancy,
//            |                        | push/pop/overflow/underflow_count
//   cfg      | cfg_wr_en              | cfg_wr_data (depth in use)
//
// One item per cycle unless a result waits for out_ready; each result appears the cycle after acceptance.
// The overflow shift moves every entry below the depth in use in parallel.
// A new item is taken while the result is being taken in the same cycle.
// Reset empties the stack, clears counters and sets depth to 16.
// A depth write clears the stack and counters like a clear item.
// ----------------------------------------------------------------------------
module return_address_stack
    import ras_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [KIND_W-1:0]  kind,
    input  logic [ADDR_W-1:0]  push_addr,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               addr_valid,
    output logic [ADDR_W-1:0]  top_addr,
    output logic [OCC_W-1:0]   occupancy,
    output logic [CNT_W-1:0]   push_count,
    output logic [CNT_W-1:0]   pop_count,
    output logic [CNT_W-1:0]   overflow_count,
    output logic [CNT_W-1:0]   underflow_count,
    input  logic               cfg_wr_en,
    input  logic [CFG_W-1:0]   cfg_wr_data
);

    cmd_t    cmd;
    status_t status;

    ras_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .kind      (kind),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    ras_dp u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .push_addr       (push_addr),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .addr_valid      (addr_valid),
        .top_addr        (top_addr),
        .occupancy       (occupancy),
        .push_count      (push_count),
        .pop_count       (pop_count),
        .overflow_count  (overflow_count),
        .underflow_count (underflow_count)
    );

endmodule

// File: bench/ras_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ras_checker
// Watches the item, result and depth ports of the return address stack. It
// keeps its own copy of the stack and counters, works out the result of each
// accepted item and compares every accepted result field by field.
// ----------------------------------------------------------------------------
module ras_checker
    import ras_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic [KIND_W-1:0]  kind,
    input  logic [ADDR_W-1:0]  push_addr,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic               addr_valid,
    input  logic [ADDR_W-1:0]  top_addr,
    input  logic [OCC_W-1:0]   occupancy,
    input  logic [CNT_W-1:0]   push_count,
    input  logic [CNT_W-1:0]   pop_count,
    input  logic [CNT_W-1:0]   overflow_count,
    input  logic [CNT_W-1:0]   underflow_count,
    input  logic               cfg_wr_en,
    input  logic [CFG_W-1:0]   cfg_wr_data,
    input  logic               done,
    output int                 fail_count
);

    typedef struct packed {
        logic              addr_valid;
        logic [ADDR_W-1:0] top_addr;
        logic [OCC_W-1:0]  occupancy;
        logic [CNT_W-1:0]  push_count;
        logic [CNT_W-1:0]  pop_count;
        logic [CNT_W-1:0]  overflow_count;
        logic [CNT_W-1:0]  underflow_count;
    } ras_result_t;

    logic [ADDR_W-1:0] stack_mem [MAX_DEPTH];
    int                stack_top;
    int                depth;
    logic [CNT_W-1:0]  n_push;
    logic [CNT_W-1:0]  n_pop;
    logic [CNT_W-1:0]  n_overflow;
    logic [CNT_W-1:0]  n_underflow;
    ras_result_t       expected_results [$];

    initial fail_count = 0;

    function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] c);
        return (c == '1) ? c : c + 1'b1;
    endfunction

    function void wipe_stack();
        for (int i = 0; i < MAX_DEPTH; i++)
        begin
            stack_mem[i] = '0;
        end
        stack_top   = 0;
        n_push      = '0;
        n_pop       = '0;
        n_overflow  = '0;
        n_underflow = '0;
    endfunction

    function void load_depth(input logic [CFG_W-1:0] v);
        if (v == '0)
        begin
            depth = 1;
        end
        else if (int'(v) > MAX_DEPTH)
        begin
            depth = MAX_DEPTH;
        end
        else
        begin
            depth = int'(v);
        end
        wipe_stack();
    endfunction

    function ras_result_t predict_op(input kind_t k, input logic [ADDR_W-1:0] a);
        ras_result_t r;
        r = '0;
        if (stack_top > depth)
        begin
            stack_top = depth;
        end
        case (k)
            KIND_PUSH:
            begin
                if (stack_top == depth)
                begin
                    // full: drop the oldest entry and shift down
                    for (int i = 0; i + 1 < depth; i++)
                    begin
                        stack_mem[i] = stack_mem[i + 1];
                    end
                    stack_mem[depth - 1] = a;
                    n_overflow = bump(n_overflow);
                end
                else
                begin
                    stack_mem[stack_top] = a;
                    stack_top++;
                end
                n_push = bump(n_push);
            end
            KIND_POP:
            begin
                if (stack_top == 0)
                begin
                    n_underflow = bump(n_underflow);
                end
                else
                begin
                    stack_top--;
                    r.top_addr   = stack_mem[stack_top];
                    r.addr_valid = 1'b1;
                    n_pop = bump(n_pop);
                end
            end
            KIND_PEEK:
            begin
                if (stack_top != 0)
                begin
                    r.top_addr   = stack_mem[stack_top - 1];
                    r.addr_valid = 1'b1;
                end
            end
            default:
            begin
                wipe_stack();
            end
        endcase
        r.occupancy       = OCC_W'(stack_top);
        r.push_count      = n_push;
        r.pop_count       = n_pop;
        r.overflow_count  = n_overflow;
        r.underflow_count = n_underflow;
        return r;
    endfunction

    task automatic check_field(input string field, input logic [ADDR_W-1:0] exp_v,
                               input logic [ADDR_W-1:0] got_v);
        if (exp_v !== got_v)
        begin
            $display("%0t ras_checker: %s expected %h got %h", $time, field, exp_v, got_v);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        ras_result_t want;
        if (!rst_n)
        begin
            load_depth(CFG_W'(16));
            expected_results.delete();
        end
        else
        begin
            if (cfg_wr_en)
            begin
                load_depth(cfg_wr_data);
            end
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t ras_checker: result with none expected, got top_addr %h",
                             $time, top_addr);
                    fail_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("addr_valid", ADDR_W'(want.addr_valid), ADDR_W'(addr_valid));
                    check_field("top_addr", want.top_addr, top_addr);
                    check_field("occupancy", ADDR_W'(want.occupancy), ADDR_W'(occupancy));
                    check_field("push_count", ADDR_W'(want.push_count), ADDR_W'(push_count));
                    check_field("pop_count", ADDR_W'(want.pop_count), ADDR_W'(pop_count));
                    check_field("overflow_count", ADDR_W'(want.overflow_count),
                                ADDR_W'(overflow_count));
                    check_field("underflow_count", ADDR_W'(want.underflow_count),
                                ADDR_W'(underflow_count));
                end
            end
            if (in_valid && in_ready)
            begin
                expected_results.push_back(predict_op(kind_t'(kind), push_addr));
            end
        end
    end

    always @(posedge done)
    begin
        if (expected_results.size() != 0)
        begin
            $display("%0t ras_checker: %0d results still expected", $time,
                     expected_results.size());
            fail_count++;
        end
    end

endmodule

// File: bench/tb_return_address_stack.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_return_address_stack
// Drives push, pop, peek and clear items into the return address stack with
// random gaps and result stalls, over a range of depth settings, and reports
// the verdict from the checker's failure count.
// ----------------------------------------------------------------------------
module tb_return_address_stack;
    import ras_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASE_ITEMS = 50;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    kind_t              kind;
    logic [ADDR_W-1:0]  push_addr;
    logic               out_valid;
    logic               out_ready;
    logic               addr_valid;
    logic [ADDR_W-1:0]  top_addr;
    logic [OCC_W-1:0]   occupancy;
    logic [CNT_W-1:0]   push_count;
    logic [CNT_W-1:0]   pop_count;
    logic [CNT_W-1:0]   overflow_count;
    logic [CNT_W-1:0]   underflow_count;
    logic               cfg_wr_en;
    logic [CFG_W-1:0]   cfg_wr_data;
    logic               done;
    int                 fail_count;
    int                 items_sent;
    int                 results_seen;
    int                 cycle_count;
    bit                 no_gaps;

    return_address_stack i_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .kind            (kind),
        .push_addr       (push_addr),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .addr_valid      (addr_valid),
        .top_addr        (top_addr),
        .occupancy       (occupancy),
        .push_count      (push_count),
        .pop_count       (pop_count),
        .overflow_count  (overflow_count),
        .underflow_count (underflow_count),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data)
    );

    ras_checker i_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .kind            (kind),
        .push_addr       (push_addr),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .addr_valid      (addr_valid),
        .top_addr        (top_addr),
        .occupancy       (occupancy),
        .push_count      (push_count),
        .pop_count       (pop_count),
        .overflow_count  (overflow_count),
        .underflow_count (underflow_count),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .done            (done),
        .fail_count      (fail_count)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (in_valid && in_ready)
        begin
            items_sent++;
        end
        if (out_valid && out_ready)
        begin
            results_seen++;
        end
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb_return_address_stack: errors");
            $finish;
        end
    end

    // result side: a random stall before each result
    initial
    begin
        int stall;
        out_ready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            stall = no_gaps ? 0 : $urandom_range(0, 3);
            if (stall > 0)
            begin
                out_ready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready = 1'b1;
            do
            begin
                @(posedge clk);
            end
            while (!out_valid);
            @(negedge clk);
        end
    end

    function automatic logic [ADDR_W-1:0] random_addr();
        int pick;
        pick = $urandom_range(0, 7);
        if (pick == 0)
        begin
            return '1;
        end
        else if (pick == 1)
        begin
            return '0;
        end
        return {$urandom, $urandom};
    endfunction

    // called just after a falling edge, returns just after a falling edge
    task automatic send_item(input kind_t k, input logic [ADDR_W-1:0] a);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 3);
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid  = 1'b1;
        kind      = k;
        push_addr = a;
        do
        begin
            @(posedge clk);
        end
        while (!in_ready);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        in_valid = 1'b0;
        while (results_seen != items_sent)
        begin
            @(negedge clk);
        end
        repeat (3) @(negedge clk);
    endtask

    task automatic write_depth(input logic [CFG_W-1:0] v);
        wait_drained();
        cfg_wr_en   = 1'b1;
        cfg_wr_data = v;
        @(negedge clk);
        cfg_wr_en   = 1'b0;
    endtask

    task automatic random_phase(input int n, input int push_pct);
        int r;
        kind_t k;
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < push_pct)
            begin
                k = KIND_PUSH;
            end
            else if (r < push_pct + (100 - push_pct) * 2 / 3)
            begin
                k = KIND_POP;
            end
            else if (r < 97)
            begin
                k = KIND_PEEK;
            end
            else
            begin
                k = KIND_CLEAR;
            end
            send_item(k, random_addr());
        end
    endtask

    initial
    begin
        logic [CFG_W-1:0] depth_plan [10];
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        kind         = KIND_PUSH;
        push_addr    = '0;
        cfg_wr_en    = 1'b0;
        cfg_wr_data  = '0;
        done         = 1'b0;
        no_gaps      = 1'b0;
        items_sent   = 0;
        results_seen = 0;
        cycle_count  = 0;
        depth_plan   = '{5'd16, 5'd1, 5'd2, 5'd31, 5'd0, 5'd5, 5'd16, 5'd3, 5'd12, 5'd16};
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // empty stack, extreme addresses, reset depth
        send_item(KIND_PEEK, '1);
        send_item(KIND_POP, '1);
        send_item(KIND_PUSH, '1);
        send_item(KIND_PUSH, '0);
        send_item(KIND_PUSH, 64'hAAAA_AAAA_AAAA_AAAA);
        send_item(KIND_PEEK, '0);
        send_item(KIND_POP, '0);
        send_item(KIND_POP, '0);
        send_item(KIND_POP, '0);
        send_item(KIND_POP, '0);
        send_item(KIND_PUSH, 64'h5555_5555_5555_5555);
        send_item(KIND_CLEAR, '1);
        send_item(KIND_PEEK, '0);

        // zero depth acts as one entry
        write_depth(5'd0);
        send_item(KIND_PUSH, 64'h0000_0000_0000_0001);
        send_item(KIND_PUSH, 64'h8000_0000_0000_0000);
        send_item(KIND_PEEK, '0);
        send_item(KIND_POP, '0);
        send_item(KIND_POP, '0);

        // overflow with shift at depth two
        write_depth(5'd2);
        send_item(KIND_PUSH, 64'h1111_1111_1111_1111);
        send_item(KIND_PUSH, 64'h2222_2222_2222_2222);
        send_item(KIND_PUSH, 64'h3333_3333_3333_3333);
        send_item(KIND_POP, '0);
        send_item(KIND_POP, '0);
        send_item(KIND_POP, '0);

        for (int p = 0; p < 10; p++)
        begin
            write_depth(depth_plan[p]);
            no_gaps = (p % 3 == 2);
            random_phase(PHASE_ITEMS, (p % 2 == 0) ? 60 : 40);
        end
        no_gaps = 1'b0;

        wait_drained();
        done = 1'b1;
        @(negedge clk);
        if (fail_count == 0)
        begin
            $display("tb_return_address_stack: clean");
        end
        else
        begin
            $display("tb_return_address_stack: errors");
        end
        $finish;
    end

endmodule

// File: sim.f
hdl/ras_pkg.sv
hdl/ras_ctrl.sv
hdl/ras_dp.sv
hdl/return_address_stack.sv
bench/ras_checker.sv
bench/tb_return_address_stack.sv
